FILE: design/plp_pkg.sv
`timescale 1ns / 1ps
package plp_pkg;

  typedef logic signed [63:0] q_t;
  typedef logic signed [47:0] out_t;

  localparam q_t QLIM = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam q_t QONE = 64'sh0000_0000_0100_0000;
  localparam q_t OUT_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam q_t OUT_LO = -64'sh0000_8000_0000_0000;

  localparam int EXPONENT_Q8_DEF = 576;

  // product shifts: unit, times one half, times two, times four
  localparam int SH_UNIT  = 24;
  localparam int SH_HALF  = 25;
  localparam int SH_TWICE = 23;
  localparam int SH_QUAD  = 22;

  localparam int CFG_IDX_W = 4;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_CENTER_X    = 4'd0;
  localparam cfg_idx_t CFG_CENTER_Y    = 4'd1;
  localparam cfg_idx_t CFG_INV_WIDTH_X = 4'd2;
  localparam cfg_idx_t CFG_INV_WIDTH_Y = 4'd3;
  localparam cfg_idx_t CFG_CROSS_TERM  = 4'd4;
  localparam cfg_idx_t CFG_PEAK_LEVEL  = 4'd5;
  localparam cfg_idx_t CFG_SKY_LEVEL   = 4'd6;
  localparam cfg_idx_t CFG_LINEAR_COEF = 4'd7;

  localparam logic signed [31:0] RST_CENTER   = 32'sd0;
  localparam logic signed [31:0] RST_INV_WID  = 32'sd77005;
  localparam logic signed [31:0] RST_CROSS    = 32'sd0;
  localparam logic signed [31:0] RST_PEAK     = 32'sd655360000;
  localparam logic signed [31:0] RST_SKY      = 32'sd0;
  localparam logic signed [31:0] RST_LIN_COEF = 32'sd65536;

  localparam int EXP_STEPS = 24;
  localparam int DIV_QW    = 49;

  typedef struct packed {
    out_t model_value;
    out_t d_center_x;
    out_t d_center_y;
    out_t d_inv_width_x;
    out_t d_inv_width_y;
    out_t d_cross_term;
    out_t d_peak_level;
    out_t d_sky_level;
    out_t d_linear_coef;
    logic domain_error;
  } res_t;

  function automatic q_t sadd(input q_t a, input q_t b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(QLIM)) return QLIM;
    if (s < -65'(QLIM)) return -QLIM;
    return s[63:0];
  endfunction

  // Q16.16 register or input to internal Q.24
  function automatic q_t widen(input logic signed [31:0] x);
    return {{24{x[31]}}, x, 8'h00};
  endfunction

  function automatic out_t sat48(input q_t v);
    if (v > OUT_HI) return 48'sh7FFF_FFFF_FFFF;
    if (v < OUT_LO) return 48'sh8000_0000_0000;
    return v[47:0];
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    logic [63:0] rem;
    res  = '0;
    bitv = 64'h4000_0000_0000_0000;
    rem  = x;
    for (int i = 0; i < 32; i++) begin
      if (bitv > rem) bitv = bitv >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bitv != '0) begin
        if (rem >= res + bitv) begin
          rem = rem - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return res;
  endfunction

  // 2^(2^-k) in Q1.30, each a floor square root of the one before
  function automatic logic [31:0] exp_root(input int k);
    logic [63:0] r;
    r = 64'h0000_0000_8000_0000;
    for (int i = 1; i <= EXP_STEPS; i++) begin
      if (i <= k) r = isqrt64(r << 30);
    end
    return r[31:0];
  endfunction

endpackage

FILE: design/plp_delay.sv
`timescale 1ns / 1ps
module plp_delay #(
  parameter int W = 64,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [0:D-1];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < D; i++) sr_r[i] <= sr_r[i-1];
    end
  end

  assign q = sr_r[D-1];

endmodule

FILE: design/plp_qmul.sv
`timescale 1ns / 1ps
module plp_qmul #(
  parameter int SHIFT = plp_pkg::SH_UNIT
) (
  input  logic         clk,
  input  logic         en,
  input  plp_pkg::q_t  a,
  input  plp_pkg::q_t  b,
  output plp_pkg::q_t  p
);
  import plp_pkg::*;

  // abs -> 32x32 partials -> sum -> shift, clamp, sign
  logic [63:0]  ua_r, ub_r;
  logic [63:0]  pp00_r, pp01_r, pp10_r, pp11_r;
  logic [127:0] full_r;
  logic         neg1_r, neg2_r, neg3_r;
  q_t           p_r;
  logic [127:0] shv;
  q_t           mag;

  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r <= a[63] ^ b[63];
      ua_r   <= a[63] ? 64'(-a) : 64'(a);
      ub_r   <= b[63] ? 64'(-b) : 64'(b);
      neg2_r <= neg1_r;
      pp00_r <= ua_r[31:0]  * ub_r[31:0];
      pp01_r <= ua_r[31:0]  * ub_r[63:32];
      pp10_r <= ua_r[63:32] * ub_r[31:0];
      pp11_r <= ua_r[63:32] * ub_r[63:32];
      neg3_r <= neg2_r;
      full_r <= {pp11_r, 64'h0} + {32'h0, pp01_r, 32'h0}
              + {32'h0, pp10_r, 32'h0} + {64'h0, pp00_r};
      p_r    <= neg3_r ? -mag : mag;
    end
  end

  always_comb begin
    shv = full_r >> SHIFT;
    mag = (|shv[127:62]) ? QLIM : q_t'({2'b00, shv[61:0]});
  end

  assign p = p_r;

endmodule

FILE: design/plp_log2.sv
`timescale 1ns / 1ps
module plp_log2 (
  input  logic               clk,
  input  logic               en,
  input  plp_pkg::q_t        z,
  output logic signed [31:0] lg
);
  import plp_pkg::*;

  logic [5:0]  b_nxt;
  logic [5:0]  b1_r;
  logic [62:0] z1_r;
  logic [62:0] shv;
  logic [30:0] m_r    [0:24];
  logic [23:0] frac_r [0:24];
  logic [5:0]  bs_r   [0:24];
  logic signed [7:0] e_int;

  // leading one
  always_comb begin
    b_nxt = '0;
    for (int i = 0; i < 63; i++) begin
      if (z[i]) b_nxt = 6'(i);
    end
  end

  always_comb begin
    shv = (b1_r >= 6'd30) ? (z1_r >> (b1_r - 6'd30)) : (z1_r << (6'd30 - b1_r));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_r      <= b_nxt;
      z1_r      <= z[62:0];
      m_r[0]    <= shv[30:0];
      bs_r[0]   <= b1_r;
      frac_r[0] <= '0;
    end
  end

  // one fraction bit per stage by squaring the mantissa
  for (genvar k = 0; k < EXP_STEPS; k++) begin : g_sq
    logic [61:0] sq;
    assign sq = m_r[k] * m_r[k];
    always_ff @(posedge clk) begin
      if (en) begin
        m_r[k+1]    <= sq[61] ? sq[61:31] : sq[60:30];
        frac_r[k+1] <= {frac_r[k][22:0], sq[61]};
        bs_r[k+1]   <= bs_r[k];
      end
    end
  end

  assign e_int = $signed({2'b00, bs_r[24]}) - 8'sd24;
  assign lg    = {e_int, frac_r[24]};

endmodule

FILE: design/plp_exp2.sv
`timescale 1ns / 1ps
module plp_exp2 (
  input  logic               clk,
  input  logic               en,
  input  logic signed [35:0] t,
  input  logic               force_one,
  input  logic               force_zero,
  output plp_pkg::q_t        zp
);
  import plp_pkg::*;

  logic [31:0]        m_r    [0:23];
  logic [23:0]        f_r    [0:23];
  logic signed [11:0] n_r    [0:23];
  logic               one_r  [0:23];
  logic               zero_r [0:23];
  q_t                 zp_r;
  logic signed [12:0] sh;
  logic [12:0]        nsh;
  q_t                 res;

  for (genvar k = 0; k < EXP_STEPS; k++) begin : g_step
    localparam logic [31:0] ROOT = exp_root(k + 1);
    logic [31:0]        m_in;
    logic [23:0]        f_in;
    logic signed [11:0] n_in;
    logic               one_in, zero_in;
    logic [63:0]        prod;
    if (k == 0) begin : g_first
      assign m_in    = 32'h4000_0000;
      assign f_in    = t[23:0];
      assign n_in    = t[35:24];
      assign one_in  = force_one;
      assign zero_in = force_zero;
    end else begin : g_next
      assign m_in    = m_r[k-1];
      assign f_in    = f_r[k-1];
      assign n_in    = n_r[k-1];
      assign one_in  = one_r[k-1];
      assign zero_in = zero_r[k-1];
    end
    assign prod = m_in * ROOT;
    always_ff @(posedge clk) begin
      if (en) begin
        m_r[k]    <= f_in[23-k] ? prod[61:30] : m_in;
        f_r[k]    <= f_in;
        n_r[k]    <= n_in;
        one_r[k]  <= one_in;
        zero_r[k] <= zero_in;
      end
    end
  end

  always_comb begin
    sh  = 13'(n_r[23]) - 13'sd6;
    nsh = 13'(-sh);
    if (one_r[23]) begin
      res = QONE;
    end else if (zero_r[23]) begin
      res = '0;
    end else if (!sh[12]) begin
      res = (sh > 13'sd31) ? QLIM : q_t'({32'h0, m_r[23]} << sh[4:0]);
    end else begin
      res = (nsh >= 13'd63) ? q_t'(0) : q_t'({32'h0, m_r[23]} >> nsh[5:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) zp_r <= res;
  end

  assign zp = zp_r;

endmodule

FILE: design/plp_div.sv
`timescale 1ns / 1ps
module plp_div (
  input  logic        clk,
  input  logic        en,
  input  plp_pkg::q_t den,
  output plp_pkg::q_t quo
);
  import plp_pkg::*;

  // 2^48 / den, truncating, one quotient bit per stage
  logic [63:0]        d0_r;
  logic               neg0_r, dz0_r;
  logic [63:0]        rem_r [0:DIV_QW-1];
  logic [DIV_QW-1:0]  quo_r [0:DIV_QW-1];
  logic [63:0]        d_r   [0:DIV_QW-1];
  logic               neg_r [0:DIV_QW-1];
  logic               dz_r  [0:DIV_QW-1];
  q_t                 quo_q_r;
  q_t                 qmag;

  always_ff @(posedge clk) begin
    if (en) begin
      d0_r   <= den[63] ? 64'(-den) : 64'(den);
      neg0_r <= den[63];
      dz0_r  <= (den == '0);
    end
  end

  for (genvar i = 0; i < DIV_QW; i++) begin : g_bit
    logic [63:0]       rem_in, d_in, rem_sh;
    logic [DIV_QW-1:0] quo_in;
    logic              neg_in, dz_in, ge;
    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = '0;
      assign d_in   = d0_r;
      assign neg_in = neg0_r;
      assign dz_in  = dz0_r;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign quo_in = quo_r[i-1];
      assign d_in   = d_r[i-1];
      assign neg_in = neg_r[i-1];
      assign dz_in  = dz_r[i-1];
    end
    assign rem_sh = {rem_in[62:0], 1'(i == 0)};
    assign ge     = (rem_sh >= d_in);
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? rem_sh - d_in : rem_sh;
        quo_r[i] <= {quo_in[DIV_QW-2:0], ge};
        d_r[i]   <= d_in;
        neg_r[i] <= neg_in;
        dz_r[i]  <= dz_in;
      end
    end
  end

  assign qmag = q_t'({15'h0, quo_r[DIV_QW-1]});

  always_ff @(posedge clk) begin
    if (en) begin
      quo_q_r <= dz_r[DIV_QW-1] ? QLIM : (neg_r[DIV_QW-1] ? -qmag : qmag);
    end
  end

  assign quo = quo_q_r;

endmodule

FILE: design/power_law_psf_model_eval_core.sv
`timescale 1ns / 1ps
// Elliptical power-law source model with gradient. Each request carries one pixel position
// (Q16.16) and returns peak/(1 + k*z + z^p) + sky in Q24.24 and, when asked, the eight
// partial derivatives; a negative radius term gives domain_error and all-zero fields.
// One request per clock enters the pipeline while in_ready is high; its depth is set by
// the chain radius term -> 26-stage log2 -> 25-stage exp2 -> 51-stage reciprocal
// divider -> the five dependent gradient products. Back-pressure freezes the whole
// pipeline only once the output register and its one-deep skid are both full. The user
// must write model parameters through the cfg port only while the block is idle (the block does not enforce it).
module power_law_psf_model_eval_core #(
  parameter int EXPONENT_Q8 = plp_pkg::EXPONENT_Q8_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [31:0]    in_pos_x,
  input  logic signed [31:0]    in_pos_y,
  input  logic                  in_want_derivatives,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [47:0]    out_model_value,
  output logic signed [47:0]    out_d_center_x,
  output logic signed [47:0]    out_d_center_y,
  output logic signed [47:0]    out_d_inv_width_x,
  output logic signed [47:0]    out_d_inv_width_y,
  output logic signed [47:0]    out_d_cross_term,
  output logic signed [47:0]    out_d_peak_level,
  output logic signed [47:0]    out_d_sky_level,
  output logic signed [47:0]    out_d_linear_coef,
  output logic                  out_domain_error,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  plp_pkg::cfg_idx_t     cfg_index,
  input  logic [31:0]           cfg_data
);
  import plp_pkg::*;

  localparam int LAST = 133;
  localparam logic signed [11:0] E1 = 12'(EXPONENT_Q8);
  localparam logic signed [11:0] E2 = 12'(EXPONENT_Q8 - 256);
  localparam q_t PZ_K = q_t'(EXPONENT_Q8) <<< 16;   // p in Q.24

  // ---------------- configuration registers ----------------
  logic signed [31:0] cx_r, cy_r, sx_r, sy_r, sxy_r, pk_r, sk_r, kl_r;
  q_t cx_w, cy_w, sx_w, sy_w, sxy_w, pk_w, sk_w, kl_w;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= RST_CENTER;
      cy_r  <= RST_CENTER;
      sx_r  <= RST_INV_WID;
      sy_r  <= RST_INV_WID;
      sxy_r <= RST_CROSS;
      pk_r  <= RST_PEAK;
      sk_r  <= RST_SKY;
      kl_r  <= RST_LIN_COEF;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CENTER_X:    cx_r  <= cfg_data;
        CFG_CENTER_Y:    cy_r  <= cfg_data;
        CFG_INV_WIDTH_X: sx_r  <= cfg_data;
        CFG_INV_WIDTH_Y: sy_r  <= cfg_data;
        CFG_CROSS_TERM:  sxy_r <= cfg_data;
        CFG_PEAK_LEVEL:  pk_r  <= cfg_data;
        CFG_SKY_LEVEL:   sk_r  <= cfg_data;
        CFG_LINEAR_COEF: kl_r  <= cfg_data;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  assign cx_w  = widen(cx_r);
  assign cy_w  = widen(cy_r);
  assign sx_w  = widen(sx_r);
  assign sy_w  = widen(sy_r);
  assign sxy_w = widen(sxy_r);
  assign pk_w  = widen(pk_r);
  assign sk_w  = widen(sk_r);
  assign kl_w  = widen(kl_r);

  // ---------------- flow control ----------------
  // en moves every stage together; it drops only when the skid holds a result.
  logic        en;
  logic        skid_full_r;
  logic        out_valid_r;
  logic [LAST:0] vld_r;

  assign en       = ~skid_full_r;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAST-1:0], in_valid};
    end
  end

  // ---------------- stage 0: offsets from centre ----------------
  q_t   x0_r, y0_r;
  logic want0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r    <= widen(in_pos_x) - cx_w;
      y0_r    <= widen(in_pos_y) - cy_w;
      want0_r <= in_want_derivatives;
    end
  end

  // ---------------- stages 1..8: scaled offsets and squares ----------------
  q_t px4, py4, cxx4, cxy4, x4, y4;
  q_t pp1_8, pp2_8, t2_8, ga8, gc8, b8, d8;

  plp_qmul #(.SHIFT(SH_UNIT)) u_px  (.clk, .en, .a(sx_w),  .b(x0_r), .p(px4));
  plp_qmul #(.SHIFT(SH_UNIT)) u_py  (.clk, .en, .a(sy_w),  .b(y0_r), .p(py4));
  plp_qmul #(.SHIFT(SH_UNIT)) u_sxx (.clk, .en, .a(sxy_w), .b(x0_r), .p(cxx4));
  plp_qmul #(.SHIFT(SH_UNIT)) u_sxy (.clk, .en, .a(sxy_w), .b(y0_r), .p(cxy4));
  plp_delay #(.W(64), .D(4)) u_dx4 (.clk, .en, .d(x0_r), .q(x4));
  plp_delay #(.W(64), .D(4)) u_dy4 (.clk, .en, .d(y0_r), .q(y4));

  plp_qmul #(.SHIFT(SH_HALF))  u_pp1 (.clk, .en, .a(px4),  .b(px4),  .p(pp1_8));
  plp_qmul #(.SHIFT(SH_HALF))  u_pp2 (.clk, .en, .a(py4),  .b(py4),  .p(pp2_8));
  plp_qmul #(.SHIFT(SH_UNIT))  u_t2  (.clk, .en, .a(cxx4), .b(y4),   .p(t2_8));
  plp_qmul #(.SHIFT(SH_TWICE)) u_ga  (.clk, .en, .a(px4),  .b(sx_w), .p(ga8));
  plp_qmul #(.SHIFT(SH_TWICE)) u_gc  (.clk, .en, .a(py4),  .b(sy_w), .p(gc8));
  plp_delay #(.W(64), .D(4)) u_db8 (.clk, .en, .d(cxy4), .q(b8));
  plp_delay #(.W(64), .D(4)) u_dd8 (.clk, .en, .d(cxx4), .q(d8));

  // ---------------- stage 9: radius term ----------------
  q_t   z9_r, g0_9_r, g1_9_r;
  logic zpos9;

  always_ff @(posedge clk) begin
    if (en) begin
      z9_r   <= sadd(sadd(pp1_8, pp2_8), t2_8);
      g0_9_r <= sadd(ga8, b8);
      g1_9_r <= sadd(gc8, d8);
    end
  end

  assign zpos9 = !z9_r[63] && (z9_r != '0);

  // ---------------- stages 10..61: z^p and z^(p-1) ----------------
  logic signed [31:0] lg35;
  logic signed [43:0] prod1, prod2;
  logic signed [35:0] te1_r, te2_r;
  logic [0:0]         zpos36;
  q_t                 zp61, zq61, kz13, kz61;

  plp_log2 u_log (.clk, .en, .z(z9_r), .lg(lg35));

  assign prod1 = 44'(lg35) * 44'(E1);
  assign prod2 = 44'(lg35) * 44'(E2);

  // floor of the Q8 exponent product
  always_ff @(posedge clk) begin
    if (en) begin
      te1_r <= prod1[43:8];
      te2_r <= prod2[43:8];
    end
  end

  plp_delay #(.W(1), .D(27)) u_dzp (.clk, .en, .d(zpos9), .q(zpos36));

  plp_exp2 u_exp_p (.clk, .en, .t(te1_r), .force_one(1'b0),
                    .force_zero(!zpos36[0]), .zp(zp61));
  plp_exp2 u_exp_q (.clk, .en, .t(te2_r), .force_one(EXPONENT_Q8 == 256),
                    .force_zero(!zpos36[0]), .zp(zq61));

  plp_qmul #(.SHIFT(SH_UNIT)) u_kz (.clk, .en, .a(kl_w), .b(z9_r), .p(kz13));
  plp_delay #(.W(64), .D(48)) u_dkz (.clk, .en, .d(kz13), .q(kz61));

  // ---------------- stages 62..113: reciprocal ----------------
  q_t den62_r, r113, pz65, kp66_r, kp121;

  always_ff @(posedge clk) begin
    if (en) den62_r <= sadd(sadd(QONE, kz61), zp61);
  end

  plp_div u_div (.clk, .en, .den(den62_r), .quo(r113));

  plp_qmul #(.SHIFT(SH_UNIT)) u_pz (.clk, .en, .a(PZ_K), .b(zq61), .p(pz65));

  always_ff @(posedge clk) begin
    if (en) kp66_r <= sadd(kl_w, pz65);
  end

  plp_delay #(.W(64), .D(55)) u_dkp (.clk, .en, .d(kp66_r), .q(kp121));

  // ---------------- stages 114..133: model value and gradient ----------------
  q_t pr117, f118_r, f133, r2_117, pr2_121, q125, z121, v7_125, v7_133;
  q_t g0_125, g1_125, v0_129, v1_129, v0_133, v1_133;
  q_t px125, py125, x125, y125, x129, y129;
  q_t qpx129, qpy129, qx129, v2_133, v3_133, v4_133, r133;
  logic [0:0] want133, zneg133;

  plp_qmul #(.SHIFT(SH_UNIT)) u_pr  (.clk, .en, .a(pk_w), .b(r113), .p(pr117));

  always_ff @(posedge clk) begin
    if (en) f118_r <= sadd(pr117, sk_w);
  end

  plp_delay #(.W(64), .D(15)) u_df (.clk, .en, .d(f118_r), .q(f133));

  plp_qmul #(.SHIFT(SH_UNIT)) u_r2  (.clk, .en, .a(r113),    .b(r113),   .p(r2_117));
  plp_qmul #(.SHIFT(SH_UNIT)) u_pr2 (.clk, .en, .a(pk_w),    .b(r2_117), .p(pr2_121));
  plp_qmul #(.SHIFT(SH_UNIT)) u_q   (.clk, .en, .a(pr2_121), .b(kp121),  .p(q125));

  plp_delay #(.W(64), .D(112)) u_dz (.clk, .en, .d(z9_r), .q(z121));
  plp_qmul #(.SHIFT(SH_UNIT)) u_v7 (.clk, .en, .a(pr2_121), .b(z121), .p(v7_125));
  plp_delay #(.W(64), .D(8)) u_dv7 (.clk, .en, .d(v7_125), .q(v7_133));

  plp_delay #(.W(64), .D(116)) u_dg0 (.clk, .en, .d(g0_9_r), .q(g0_125));
  plp_delay #(.W(64), .D(116)) u_dg1 (.clk, .en, .d(g1_9_r), .q(g1_125));
  plp_qmul #(.SHIFT(SH_UNIT)) u_v0 (.clk, .en, .a(q125), .b(g0_125), .p(v0_129));
  plp_qmul #(.SHIFT(SH_UNIT)) u_v1 (.clk, .en, .a(q125), .b(g1_125), .p(v1_129));
  plp_delay #(.W(64), .D(4)) u_dv0 (.clk, .en, .d(v0_129), .q(v0_133));
  plp_delay #(.W(64), .D(4)) u_dv1 (.clk, .en, .d(v1_129), .q(v1_133));

  plp_delay #(.W(64), .D(121)) u_dpx (.clk, .en, .d(px4), .q(px125));
  plp_delay #(.W(64), .D(121)) u_dpy (.clk, .en, .d(py4), .q(py125));
  plp_delay #(.W(64), .D(121)) u_dx  (.clk, .en, .d(x4),  .q(x125));
  plp_delay #(.W(64), .D(121)) u_dy  (.clk, .en, .d(y4),  .q(y125));
  plp_delay #(.W(64), .D(4))   u_dx2 (.clk, .en, .d(x125), .q(x129));
  plp_delay #(.W(64), .D(4))   u_dy2 (.clk, .en, .d(y125), .q(y129));

  plp_qmul #(.SHIFT(SH_UNIT)) u_qpx (.clk, .en, .a(q125),   .b(px125), .p(qpx129));
  plp_qmul #(.SHIFT(SH_UNIT)) u_qpy (.clk, .en, .a(q125),   .b(py125), .p(qpy129));
  plp_qmul #(.SHIFT(SH_UNIT)) u_qx  (.clk, .en, .a(q125),   .b(x125),  .p(qx129));
  plp_qmul #(.SHIFT(SH_QUAD)) u_v2  (.clk, .en, .a(qpx129), .b(x129),  .p(v2_133));
  plp_qmul #(.SHIFT(SH_QUAD)) u_v3  (.clk, .en, .a(qpy129), .b(y129),  .p(v3_133));
  plp_qmul #(.SHIFT(SH_UNIT)) u_v4  (.clk, .en, .a(qx129),  .b(y129),  .p(v4_133));

  plp_delay #(.W(64), .D(20))  u_dr   (.clk, .en, .d(r113),     .q(r133));
  plp_delay #(.W(1),  .D(133)) u_dwnt (.clk, .en, .d(want0_r),  .q(want133));
  plp_delay #(.W(1),  .D(124)) u_dneg (.clk, .en, .d(z9_r[63]), .q(zneg133));

  // ---------------- result assembly ----------------
  res_t res_nxt, out_r, skid_r;

  always_comb begin
    res_nxt = '0;
    if (zneg133[0]) begin
      res_nxt.domain_error = 1'b1;
    end else begin
      res_nxt.model_value = sat48(f133);
      if (want133[0]) begin
        res_nxt.d_center_x    = sat48(v0_133);
        res_nxt.d_center_y    = sat48(v1_133);
        res_nxt.d_inv_width_x = sat48(-v2_133);
        res_nxt.d_inv_width_y = sat48(-v3_133);
        res_nxt.d_cross_term  = sat48(-v4_133);
        res_nxt.d_peak_level  = sat48(r133);
        res_nxt.d_sky_level   = sat48(QONE);
        res_nxt.d_linear_coef = sat48(-v7_133);
      end
    end
  end

  // output register with a one-deep skid behind it
  logic incoming;
  assign incoming = en && vld_r[LAST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_full_r) begin
        out_valid_r <= 1'b1;
        skid_full_r <= 1'b0;
      end else begin
        out_valid_r <= incoming;
      end
    end else if (incoming) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_r <= skid_full_r ? skid_r : res_nxt;
    end else if (incoming) begin
      skid_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_model_value   = out_r.model_value;
  assign out_d_center_x    = out_r.d_center_x;
  assign out_d_center_y    = out_r.d_center_y;
  assign out_d_inv_width_x = out_r.d_inv_width_x;
  assign out_d_inv_width_y = out_r.d_inv_width_y;
  assign out_d_cross_term  = out_r.d_cross_term;
  assign out_d_peak_level  = out_r.d_peak_level;
  assign out_d_sky_level   = out_r.d_sky_level;
  assign out_d_linear_coef = out_r.d_linear_coef;
  assign out_domain_error  = out_r.domain_error;

  // ---------------- checks ----------------
  a_skid_needs_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> out_valid_r)
    else $error("skid holds a result while output register is empty");

  a_skid_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_full_r) |-> $past(out_valid_r && !out_ready))
    else $error("skid filled without an output stall");

  a_err_zeroes : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.domain_error) |->
      (out_r.model_value == '0 && out_r.d_peak_level == '0 && out_r.d_sky_level == '0))
    else $error("domain error with non-zero fields");

  a_sky_unit : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.d_sky_level != '0) |-> (out_r.d_sky_level == sat48(QONE)))
    else $error("sky derivative is not one");

endmodule
